>>> sv/rfidmtd_pkg.sv
// ----------------------------------------------------------------------------
// rfidmtd_pkg
// Shared types and constants of the RFID Manchester tag decoder.
// ----------------------------------------------------------------------------
package rfidmtd_pkg;

	localparam int DATA_ROWS_DEF  = 10;
	localparam int STORE_BITS_DEF = 64;

	localparam int HP_W       = 2;
	localparam int TICK_W     = 8;
	localparam int HDR_W      = 5;
	localparam int CNT_W      = 6;
	localparam int POS_W      = CNT_W + 1;
	localparam int TAG_W      = 40;
	localparam int CFG_DATA_W = 8;
	localparam int NIB_BITS   = 4;

	localparam logic [HDR_W-1:0]  HEADER_EDGES    = 5'd17;
	localparam logic [TICK_W-1:0] QUARTER_RESET   = 8'd64;
	localparam logic [CNT_W-1:0]  FRAME_END_RESET = 6'd54;

	// Gap codes of the half-period counter.
	localparam logic [HP_W-1:0] HP_NONE = 2'd0;
	localparam logic [HP_W-1:0] HP_ONE  = 2'd1;
	localparam logic [HP_W-1:0] HP_TWO  = 2'd2;

	typedef enum logic {
		CFG_QUARTER   = 1'b0,
		CFG_FRAME_END = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FS_OK      = 2'd0,
		FS_ROW_ERR = 2'd1,
		FS_COL_ERR = 2'd2
	} frame_status_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_STOP   = 2'd1,
		PH_HEADER = 2'd2,
		PH_READ   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_START = 2'd1,
		ST_CHECK = 2'd2
	} ctl_state_t;

	typedef struct packed {
		logic [HP_W-1:0]   half_periods;
		logic [TICK_W-1:0] sub_ticks;
		logic              demod_level;
	} in_t;

	typedef struct packed {
		logic             next_edge_rising;
		logic             frame_done;
		logic [1:0]       frame_status;
		logic [TAG_W-1:0] tag_id;
	} out_t;

	typedef struct packed {
		logic frame_end;
		logic next_rising;
		logic edge_rising;
	} dec_stat_t;

	typedef struct packed {
		logic             done;
		logic [1:0]       status;
		logic [TAG_W-1:0] tag;
	} chk_res_t;

endpackage

>>> sv/rfidmtd_edge.sv
// ----------------------------------------------------------------------------
// rfidmtd_edge
// Edge sequencer: stop bit and header search, Manchester bit recovery into
// the frame store, and tracking of the edge polarity to wait for.
// ----------------------------------------------------------------------------
module rfidmtd_edge
	import rfidmtd_pkg::*;
#(
	parameter int STORE_BITS = STORE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  in_t                   word,
	input  logic [TICK_W-1:0]     quarter_threshold,
	input  logic [CNT_W-1:0]      frame_end_count,
	output logic [STORE_BITS-1:0] frame_store,
	output dec_stat_t             stat
);

	phase_t                ph_q, ph_d;
	logic [HDR_W-1:0]      hdr_q, hdr_d, hdr_inc;
	logic                  last_q, last_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic [STORE_BITS-1:0] store_q, store_d;
	logic                  er_q, er_d;
	logic                  frame_end;
	logic                  set_en;
	logic [POS_W-1:0]      set_pos;
	logic [POS_W-1:0]      cnt_sum;

	always_comb begin
		ph_d      = ph_q;
		hdr_d     = hdr_q;
		last_d    = last_q;
		cnt_d     = cnt_q;
		store_d   = store_q;
		er_d      = er_q;
		frame_end = 1'b0;
		set_en    = 1'b0;
		set_pos   = {1'b0, cnt_q};
		hdr_inc   = hdr_q + 5'd1;
		cnt_sum   = {1'b0, cnt_q};
		case (ph_q)
			PH_IDLE: begin
				er_d = 1'b0;
				ph_d = PH_STOP;
			end
			PH_STOP: begin
				er_d = 1'b1;
				if (word.half_periods == HP_ONE) begin
					hdr_d = 5'd1;
					ph_d  = PH_HEADER;
				end else begin
					ph_d = PH_IDLE;
				end
			end
			PH_HEADER: begin
				if (word.half_periods == HP_NONE) begin
					hdr_d = hdr_inc;
					if (hdr_inc == HEADER_EDGES) begin
						last_d  = 1'b1;
						cnt_d   = '0;
						store_d = '0;
						er_d    = 1'b0;
						ph_d    = PH_READ;
					end else begin
						er_d = ~er_q;
					end
				end else begin
					er_d = 1'b0;
					ph_d = PH_STOP;
				end
			end
			PH_READ: begin
				// A short one-period gap repeats the previous bit; a longer one yields a
				// zero at low level, else a zero followed by a one, as a two-period gap does.
				if (word.half_periods == HP_ONE && word.sub_ticks < quarter_threshold) begin
					set_en  = last_q;
					cnt_sum = {1'b0, cnt_q} + 7'd1;
				end else if (word.half_periods == HP_ONE && !word.demod_level) begin
					last_d  = 1'b0;
					cnt_sum = {1'b0, cnt_q} + 7'd1;
				end else if (word.half_periods == HP_ONE || word.half_periods == HP_TWO) begin
					set_en  = 1'b1;
					set_pos = {1'b0, cnt_q} + 7'd1;
					last_d  = 1'b1;
					cnt_sum = {1'b0, cnt_q} + 7'd2;
				end
				cnt_d = cnt_sum[CNT_W-1:0];
				if (cnt_sum > {1'b0, frame_end_count}) begin
					frame_end = 1'b1;
					er_d      = 1'b1;
					ph_d      = PH_IDLE;
				end
			end
			default: begin
				ph_d = PH_IDLE;
			end
		endcase
		for (int i = 0; i < STORE_BITS; i++) begin
			if (set_en && set_pos == POS_W'(i)) begin
				store_d[i] = 1'b1;
			end
		end
	end

	always_comb begin
		frame_store      = store_q;
		stat.frame_end   = frame_end;
		stat.next_rising = er_d;
		stat.edge_rising = er_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_IDLE;
			hdr_q   <= '0;
			last_q  <= 1'b0;
			cnt_q   <= '0;
			store_q <= '0;
			er_q    <= 1'b1;
		end else if (step) begin
			ph_q    <= ph_d;
			hdr_q   <= hdr_d;
			last_q  <= last_d;
			cnt_q   <= cnt_d;
			store_q <= store_d;
			er_q    <= er_d;
		end
	end

endmodule

>>> sv/rfidmtd_check.sv
// ----------------------------------------------------------------------------
// rfidmtd_check
// Bit-serial frame checker: shifts the frame store out one bit per cycle,
// assembles the tag and checks row and column even parity.
// ----------------------------------------------------------------------------
module rfidmtd_check
	import rfidmtd_pkg::*;
#(
	parameter int DATA_ROWS  = DATA_ROWS_DEF,
	parameter int STORE_BITS = STORE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [STORE_BITS-1:0] frame_store,
	output chk_res_t              result
);

	localparam int ROW_W = $clog2(DATA_ROWS + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [2:0]            col_q;
	logic [ROW_W-1:0]      row_q;
	logic [STORE_BITS-1:0] sr_q;
	logic [TAG_W-1:0]      tag_q;
	logic                  rpar_q;
	logic [NIB_BITS-1:0]   cpar_q;
	logic                  row_err_q;
	logic                  col_err_q;
	logic                  cur_bit;
	logic                  data_row;
	logic                  data_col;
	logic                  last_step;

	assign cur_bit   = sr_q[0];
	assign data_row  = row_q < ROW_W'(DATA_ROWS);
	assign data_col  = col_q < 3'(NIB_BITS);
	assign last_step = busy_q && !data_row && col_q == 3'(NIB_BITS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			col_q  <= '0;
			row_q  <= '0;
		end else begin
			done_q <= last_step;
			if (start) begin
				busy_q <= 1'b1;
				col_q  <= '0;
				row_q  <= '0;
			end else if (busy_q) begin
				if (last_step) begin
					busy_q <= 1'b0;
				end
				if (data_row && !data_col) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + 3'd1;
				end
			end
		end
	end

	// After a failing row the remaining nibbles enter the tag as zeros.
	always_ff @(posedge clk) begin
		if (start) begin
			sr_q      <= frame_store;
			tag_q     <= '0;
			rpar_q    <= 1'b0;
			cpar_q    <= '0;
			row_err_q <= 1'b0;
			col_err_q <= 1'b0;
		end else if (busy_q) begin
			sr_q <= sr_q >> 1;
			if (data_row) begin
				if (data_col) begin
					tag_q <= {tag_q[TAG_W-2:0], cur_bit & ~row_err_q};
					rpar_q <= rpar_q ^ cur_bit;
					cpar_q[col_q[1:0]] <= cpar_q[col_q[1:0]] ^ cur_bit;
				end else begin
					if (!row_err_q && rpar_q != cur_bit) begin
						row_err_q <= 1'b1;
					end
					rpar_q <= 1'b0;
				end
			end else if (cpar_q[col_q[1:0]] != cur_bit) begin
				col_err_q <= 1'b1;
			end
		end
	end

	always_comb begin
		result.done = done_q;
		result.tag  = tag_q;
		if (row_err_q) begin
			result.status = FS_ROW_ERR;
		end else if (col_err_q) begin
			result.status = FS_COL_ERR;
		end else begin
			result.status = FS_OK;
		end
	end

endmodule

>>> sv/rfid_manchester_tag_decoder.sv
// ----------------------------------------------------------------------------
// rfid_manchester_tag_decoder
// Edge-event Manchester decoder for 64-bit read-only RFID tag frames.
// ----------------------------------------------------------------------------
// Every accepted edge event yields exactly one result word. An event that does
// not close a frame has its result loaded straight into the output register
// on acceptance. The event that closes a frame starts a parity scan that
// walks the frame store one bit per cycle, 5*DATA_ROWS+4 bits, after the
// start state; its result is loaded from the check state when the scan ends;
// no new event is taken during the scan. Configuration writes are always
// taken (cfg_ready is tied high) and belong between events.
module rfid_manchester_tag_decoder
	import rfidmtd_pkg::*;
#(
	parameter int DATA_ROWS  = DATA_ROWS_DEF,
	parameter int STORE_BITS = STORE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctl_state_t            state_q, state_d;
	logic [TICK_W-1:0]     quarter_q;
	logic [CNT_W-1:0]      frame_end_q;
	logic                  out_valid_q;
	out_t                  out_q;
	logic                  in_acc;
	logic                  chk_start;
	logic [STORE_BITS-1:0] frame_store;
	dec_stat_t             dec_stat;
	chk_res_t              chk_res;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quarter_q   <= QUARTER_RESET;
			frame_end_q <= FRAME_END_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_QUARTER:   quarter_q <= cfg_data;
				CFG_FRAME_END: frame_end_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	rfidmtd_edge #(
		.STORE_BITS(STORE_BITS)
	) u_edge (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (in_acc),
		.word             (in_data),
		.quarter_threshold(quarter_q),
		.frame_end_count  (frame_end_q),
		.frame_store      (frame_store),
		.stat             (dec_stat)
	);

	rfidmtd_check #(
		.DATA_ROWS (DATA_ROWS),
		.STORE_BITS(STORE_BITS)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (chk_start),
		.frame_store(frame_store),
		.result     (chk_res)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && dec_stat.frame_end) begin
					state_d = ST_START;
				end
			end
			ST_START: state_d = ST_CHECK;
			ST_CHECK: begin
				if (chk_res.done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		chk_start = (state_q == ST_START);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((in_acc && !dec_stat.frame_end) || (state_q == ST_CHECK && chk_res.done)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The output word is loaded only when the register is empty or draining.
	always_ff @(posedge clk) begin
		if (in_acc && !dec_stat.frame_end) begin
			out_q.next_edge_rising <= dec_stat.next_rising;
			out_q.frame_done       <= 1'b0;
			out_q.frame_status     <= FS_OK;
			out_q.tag_id           <= '0;
		end else if (state_q == ST_CHECK && chk_res.done) begin
			out_q.next_edge_rising <= dec_stat.edge_rising;
			out_q.frame_done       <= 1'b1;
			out_q.frame_status     <= chk_res.status;
			out_q.tag_id           <= chk_res.tag;
		end
	end

	a_done_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		chk_res.done |-> state_q == ST_CHECK)
		else $error("parity scan finished outside the check state");

	a_frame_waits_rising: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_done |-> out_data.next_edge_rising)
		else $error("completed frame does not wait for a rising edge");

	a_no_frame_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.frame_done |->
			out_data.frame_status == FS_OK && out_data.tag_id == '0)
		else $error("status or tag reported without a completed frame");

	a_no_accept_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_START |=> state_q == ST_CHECK && !in_acc)
		else $error("event accepted while the parity scan runs");

endmodule
